FILE: hw/rtl/sprt_pkg.sv
// ----------------------------------------------------------------------------
// Shared page refcount table package
// Field widths, status codes and the transfer payload types of the table.
// ----------------------------------------------------------------------------
package sprt_pkg;

  localparam int unsigned VaW  = 39;
  localparam int unsigned KeyW = 32;
  localparam int unsigned PaW  = 56;
  localparam int unsigned RefW = 16;
  localparam int unsigned StW  = 3;

  localparam logic [StW-1:0] StHit      = 3'd0;
  localparam logic [StW-1:0] StAlloc    = 3'd1;
  localparam logic [StW-1:0] StFull     = 3'd2;
  localparam logic [StW-1:0] StKept     = 3'd3;
  localparam logic [StW-1:0] StFreed    = 3'd4;
  localparam logic [StW-1:0] StNoSlot   = 3'd5;
  localparam logic [StW-1:0] StUnmapped = 3'd6;

  localparam logic OpAttach = 1'b0;
  localparam logic OpDetach = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [KeyW-1:0] share_key;
    logic [VaW-1:0]  detach_address;
    logic [PaW-1:0]  fresh_page;
    logic            is_mapped;
  } req_t;

  typedef struct packed {
    logic [StW-1:0] status;
    logic [VaW-1:0] shared_va;
    logic [PaW-1:0] page_address;
    logic           clear_mapping;
    logic           count_saturated;
  } rsp_t;

endpackage

FILE: hw/rtl/shared_page_refcount_table.sv
// ----------------------------------------------------------------------------
// Shared page refcount table
// Fixed table of shared pages with per-slot reference counts, searched one
// slot per cycle by a single compare and count unit.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid_i / in_ready_o          input      sprt_pkg::req_t
//   out      out_valid_o / out_ready_i        output     sprt_pkg::rsp_t
//   cfg      cfg_we_i                         input      cfg_wdata_i (base)
//
// A transfer is accepted in the idle state, scanned one slot at a time until
// a key or address hit or the last slot (up to SLOTS slots), and then moved
// from the done state into the output register. The scan shares one slot's
// compares and one count adder; a detach of an unmapped address skips the scan.
// Reset clears the valid bits, the base register and the control state.
// A result waiting at the output holds the block in its done state; the
// next transfer is taken as soon as that result enters the output register.
module shared_page_refcount_table #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sprt_pkg::req_t             in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sprt_pkg::rsp_t             out_o,
  input  logic                       cfg_we_i,
  input  logic [sprt_pkg::VaW-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [sprt_pkg::VaW-1:0] VaStep = sprt_pkg::VaW'(1) << PAGE_SHIFT;
  localparam logic [sprt_pkg::RefW-1:0] RefOne = sprt_pkg::RefW'(1);
  localparam logic [sprt_pkg::RefW-1:0] RefMinusOne = '1;

  localparam logic [1:0] StateIdle = 2'd0;
  localparam logic [1:0] StateScan = 2'd1;
  localparam logic [1:0] StateDone = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [sprt_pkg::VaW-1:0]    va_q, va_d;
  logic [sprt_pkg::VaW-1:0]    base_q;
  sprt_pkg::req_t              req_q;
  sprt_pkg::rsp_t              res_q, res_d;
  sprt_pkg::rsp_t              out_q;
  logic                        out_valid_q, out_valid_d;
  logic                        free_found_q, free_found_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;
  logic [sprt_pkg::VaW-1:0]    free_va_q, free_va_d;

  logic [SLOTS-1:0]            valid_q, valid_d;
  logic [sprt_pkg::KeyW-1:0]   key_q  [SLOTS];
  logic [sprt_pkg::PaW-1:0]    page_q [SLOTS];
  logic [sprt_pkg::RefW-1:0]   refs_q [SLOTS];

  logic                        accept;
  logic                        key_hit, va_hit, last, free_now;
  logic [sprt_pkg::KeyW-1:0]   key_cur;
  logic [sprt_pkg::PaW-1:0]    page_cur;
  logic [sprt_pkg::RefW-1:0]   refs_cur, refs_sum;
  logic                        refs_sat;
  logic [IdxW-1:0]             alloc_idx;
  logic [sprt_pkg::VaW-1:0]    alloc_va;
  logic                        alloc_en, refs_we;
  logic [sprt_pkg::RefW-1:0]   refs_wdata;

  assign in_ready_o  = (state_q == StateIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign key_cur  = key_q[idx_q];
  assign page_cur = page_q[idx_q];
  assign refs_cur = refs_q[idx_q];
  assign key_hit  = valid_q[idx_q] && (key_cur == req_q.share_key);
  assign va_hit   = valid_q[idx_q] && (va_q == req_q.detach_address);
  assign last     = (idx_q == LastIdx);
  assign free_now = !free_found_q && !valid_q[idx_q];
  assign refs_sat = (refs_cur == RefMinusOne);
  assign refs_sum = refs_cur + ((req_q.operation == sprt_pkg::OpDetach) ? RefMinusOne : RefOne);
  assign alloc_idx = free_found_q ? free_idx_q : idx_q;
  assign alloc_va  = free_found_q ? free_va_q : va_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    va_d         = va_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    free_va_d    = free_va_q;
    valid_d      = valid_q;
    alloc_en     = 1'b0;
    refs_we      = 1'b0;
    refs_wdata   = refs_sum;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StateIdle: begin
        if (accept) begin
          idx_d        = '0;
          va_d         = base_q;
          free_found_d = 1'b0;
          res_d        = '0;
          if (in_i.operation == sprt_pkg::OpDetach && !in_i.is_mapped) begin
            res_d.status = sprt_pkg::StUnmapped;
            state_d      = StateDone;
          end else begin
            state_d = StateScan;
          end
        end
      end
      StateScan: begin
        idx_d = idx_q + IdxW'(1);
        va_d  = va_q + VaStep;
        if (free_now) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
          free_va_d    = va_q;
        end
        if (req_q.operation == sprt_pkg::OpAttach) begin
          if (key_hit) begin
            refs_we                = !refs_sat;
            res_d.status           = sprt_pkg::StHit;
            res_d.shared_va        = va_q;
            res_d.page_address     = page_cur;
            res_d.count_saturated  = refs_sat;
            state_d                = StateDone;
          end else if (last) begin
            if (free_found_q || free_now) begin
              alloc_en             = 1'b1;
              valid_d[alloc_idx]   = 1'b1;
              res_d.status         = sprt_pkg::StAlloc;
              res_d.shared_va      = alloc_va;
              res_d.page_address   = req_q.fresh_page;
            end else begin
              res_d.status = sprt_pkg::StFull;
            end
            state_d = StateDone;
          end
        end else begin
          if (va_hit) begin
            res_d.clear_mapping = 1'b1;
            if (refs_cur <= RefOne) begin
              valid_d[idx_q]     = 1'b0;
              res_d.status       = sprt_pkg::StFreed;
              res_d.page_address = page_cur;
            end else begin
              refs_we      = 1'b1;
              res_d.status = sprt_pkg::StKept;
            end
            state_d = StateDone;
          end else if (last) begin
            res_d.status        = sprt_pkg::StNoSlot;
            res_d.clear_mapping = 1'b1;
            state_d             = StateDone;
          end
        end
      end
      StateDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateIdle;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      base_q       <= '0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
      free_found_q <= free_found_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    va_q       <= va_d;
    res_q      <= res_d;
    free_idx_q <= free_idx_d;
    free_va_q  <= free_va_d;
    if (accept) begin
      req_q <= in_i;
    end
    if (state_q == StateDone && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      key_q[alloc_idx]  <= req_q.share_key;
      page_q[alloc_idx] <= req_q.fresh_page;
      refs_q[alloc_idx] <= RefOne;
    end else if (refs_we) begin
      refs_q[idx_q] <= refs_wdata;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateScan |=> state_q == StateScan || state_q == StateDone)
    else $error("Scan left for an unexpected state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_en |-> !valid_q[alloc_idx])
    else $error("Allocation into a slot that is in use.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateIdle |=> $countones(valid_q) == $past($countones(valid_q)))
    else $error("Slot valid bits changed while idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateDone && (!out_valid_q || out_ready_i) |=> out_valid_o)
    else $error("Finished result did not reach the output register.");

endmodule

FILE: tb/shared_page_refcount_table_tb.sv
// ----------------------------------------------------------------------------
// Shared page refcount table testbench
// Drives attach and detach requests through the table under several base
// addresses and handshake idling patterns. Every response is checked field by
// field against a cycle-free table model that is updated as each request
// transfer is taken.
// ----------------------------------------------------------------------------
module shared_page_refcount_table_tb;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned KEY_POOL    = 24;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  sprt_pkg::req_t           in_i        = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  sprt_pkg::rsp_t           out_o;
  logic                     cfg_we_i    = 1'b0;
  logic [sprt_pkg::VaW-1:0] cfg_wdata_i = '0;

  sprt_pkg::req_t req_backlog[$];
  sprt_pkg::rsp_t awaited_rsps[$];

  logic [sprt_pkg::VaW-1:0]  table_base = '0;
  logic                      slot_live[SLOTS];
  logic [sprt_pkg::KeyW-1:0] slot_key[SLOTS];
  logic [sprt_pkg::PaW-1:0]  slot_page[SLOTS];
  logic [sprt_pkg::RefW-1:0] slot_count[SLOTS];
  logic [sprt_pkg::KeyW-1:0] key_pool[KEY_POOL];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int error_count    = 0;
  int reqs_taken     = 0;
  int rsps_checked   = 0;
  int status_seen[8];

  shared_page_refcount_table #(
    .SLOTS     (SLOTS),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [sprt_pkg::VaW-1:0] slot_va(int idx);
    return table_base + (sprt_pkg::VaW'(idx) << PAGE_SHIFT);
  endfunction

  function automatic logic [sprt_pkg::VaW-1:0] random_va();
    return sprt_pkg::VaW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [sprt_pkg::PaW-1:0] random_pa();
    return sprt_pkg::PaW'({$urandom(), $urandom()});
  endfunction

  function automatic sprt_pkg::req_t scrambled_req();
    sprt_pkg::req_t rq;
    rq.operation      = 1'($urandom_range(0, 1));
    rq.share_key      = $urandom();
    rq.detach_address = random_va();
    rq.fresh_page     = random_pa();
    rq.is_mapped      = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic sprt_pkg::req_t attach_req(logic [sprt_pkg::KeyW-1:0] key,
                                                logic [sprt_pkg::PaW-1:0] page);
    sprt_pkg::req_t rq;
    rq            = scrambled_req();
    rq.operation  = sprt_pkg::OpAttach;
    rq.share_key  = key;
    rq.fresh_page = page;
    return rq;
  endfunction

  function automatic sprt_pkg::req_t detach_req(logic [sprt_pkg::VaW-1:0] va, logic mapped);
    sprt_pkg::req_t rq;
    rq                = scrambled_req();
    rq.operation      = sprt_pkg::OpDetach;
    rq.detach_address = va;
    rq.is_mapped      = mapped;
    return rq;
  endfunction

  function automatic sprt_pkg::rsp_t predict_table_op(sprt_pkg::req_t rq);
    sprt_pkg::rsp_t r;
    int             free_slot;
    r         = '0;
    free_slot = -1;
    if (rq.operation == sprt_pkg::OpAttach) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && slot_key[i] == rq.share_key) begin
          r.status          = sprt_pkg::StHit;
          r.shared_va       = slot_va(i);
          r.page_address    = slot_page[i];
          r.count_saturated = (slot_count[i] == '1);
          if (slot_count[i] != '1) begin
            slot_count[i] = slot_count[i] + 1'b1;
          end
          return r;
        end
        if (!slot_live[i] && free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        slot_live[free_slot]  = 1'b1;
        slot_key[free_slot]   = rq.share_key;
        slot_page[free_slot]  = rq.fresh_page;
        slot_count[free_slot] = sprt_pkg::RefW'(1);
        r.status              = sprt_pkg::StAlloc;
        r.shared_va           = slot_va(free_slot);
        r.page_address        = rq.fresh_page;
      end else begin
        r.status = sprt_pkg::StFull;
      end
      return r;
    end
    if (!rq.is_mapped) begin
      r.status = sprt_pkg::StUnmapped;
      return r;
    end
    r.clear_mapping = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_va(i) == rq.detach_address) begin
        if (slot_count[i] <= 1) begin
          slot_count[i]  = '0;
          slot_live[i]   = 1'b0;
          r.status       = sprt_pkg::StFreed;
          r.page_address = slot_page[i];
        end else begin
          slot_count[i] = slot_count[i] - 1'b1;
          r.status      = sprt_pkg::StKept;
        end
        return r;
      end
    end
    r.status = sprt_pkg::StNoSlot;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        awaited_rsps.push_back(predict_table_op(in_i));
        reqs_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_i       <= req_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sprt_pkg::rsp_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          $error("Response transfer with no request outstanding: %p", out_o);
          error_count++;
        end else begin
          want = awaited_rsps.pop_front();
          rsps_checked++;
          status_seen[want.status]++;
          if (out_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_o.status);
            error_count++;
          end
          if (out_o.shared_va !== want.shared_va) begin
            $error("shared_va: expected %h, got %h", want.shared_va, out_o.shared_va);
            error_count++;
          end
          if (out_o.page_address !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address,
                   out_o.page_address);
            error_count++;
          end
          if (out_o.clear_mapping !== want.clear_mapping) begin
            $error("clear_mapping: expected %b, got %b", want.clear_mapping,
                   out_o.clear_mapping);
            error_count++;
          end
          if (out_o.count_saturated !== want.count_saturated) begin
            $error("count_saturated: expected %b, got %b", want.count_saturated,
                   out_o.count_saturated);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || awaited_rsps.size() != 0);
  endtask

  task automatic write_base(logic [sprt_pkg::VaW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    table_base  = value;
  endtask

  task automatic fill_random(int count, int attach_pct);
    int pick;
    int idx;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, SLOTS - 1);
      if (pick < attach_pct) begin
        req_backlog.push_back(attach_req(key_pool[$urandom_range(0, KEY_POOL - 1)],
                                         random_pa()));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          req_backlog.push_back(detach_req(slot_va(idx), 1'b1));
        end else if (pick < 88) begin
          req_backlog.push_back(detach_req(random_va(), 1'b1));
        end else if (pick < 96) begin
          req_backlog.push_back(detach_req(slot_va(idx), 1'b0));
        end else begin
          req_backlog.push_back(attach_req($urandom(), random_pa()));
        end
      end
    end
  endtask

  initial begin
    logic [sprt_pkg::VaW-1:0] phase_base[PHASES];
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_page[i]  = '0;
      slot_count[i] = '0;
    end
    foreach (status_seen[i]) status_seen[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
    phase_base[0] = '1;
    phase_base[1] = '0;
    phase_base[2] = random_va() & ~sprt_pkg::VaW'((1 << PAGE_SHIFT) - 1);
    phase_base[3] = '0 - (sprt_pkg::VaW'(5) << PAGE_SHIFT);
    phase_base[4] = random_va();
    phase_base[5] = random_va();
    phase_base[6] = '1 - sprt_pkg::VaW'(3);
    phase_base[7] = '0;

    wait (rst_ni);
    req_backlog.push_back(detach_req(slot_va(0), 1'b0));
    req_backlog.push_back(detach_req(slot_va(0), 1'b1));
    req_backlog.push_back(attach_req('0, '1));
    req_backlog.push_back(attach_req('0, random_pa()));
    req_backlog.push_back(attach_req('1, '0));
    for (int i = 2; i < SLOTS; i++) begin
      req_backlog.push_back(attach_req(32'hA5C3_0000 | sprt_pkg::KeyW'(i), random_pa()));
    end
    req_backlog.push_back(attach_req(32'hA5C3_FFFF, random_pa()));
    req_backlog.push_back(detach_req(slot_va(0), 1'b1));
    req_backlog.push_back(detach_req(slot_va(0), 1'b1));
    req_backlog.push_back(detach_req(slot_va(1), 1'b0));
    req_backlog.push_back(attach_req(32'h0F0F_0F0F, random_pa()));
    req_backlog.push_back(detach_req('1, 1'b1));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_base(phase_base[p]);
      send_idle_pct  = (p % 4 == 1) ? 46 : (p % 4 == 3) ? 32 : 0;
      recv_stall_pct = (p % 4 == 2) ? 46 : (p % 4 == 3) ? 32 : 0;
      fill_random(PHASE_ITEMS, (p % 2 == 0) ? 60 : 40);
      wait_drained();
    end

    repeat (SLOTS + 4) @(posedge clk_i);
    $display("Covered %0d requests and %0d checked responses over %0d base settings.",
             reqs_taken, rsps_checked, PHASES + 1);
    $display("hit %0d, alloc %0d, full %0d, kept %0d, freed %0d, no slot %0d, unmapped %0d",
             status_seen[sprt_pkg::StHit], status_seen[sprt_pkg::StAlloc],
             status_seen[sprt_pkg::StFull], status_seen[sprt_pkg::StKept],
             status_seen[sprt_pkg::StFreed], status_seen[sprt_pkg::StNoSlot],
             status_seen[sprt_pkg::StUnmapped]);
    if (error_count == 0 && awaited_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sprt_pkg.sv
hw/rtl/shared_page_refcount_table.sv
tb/shared_page_refcount_table_tb.sv
